// File: rtl/pig_pkg.sv
`timescale 1ns / 1ps
package pig_pkg;

  localparam int VAR_W       = 8;
  localparam int TERM_DEPTH  = 256;
  localparam int PRIME_DEPTH = 64;
  localparam int IDX_W       = 8;
  localparam int CNT_W       = 9;
  localparam int PIDX_W      = 6;
  localparam int PCNT_W      = 7;
  localparam int NV_W        = 4;
  localparam logic [NV_W-1:0] NUM_VARS_MAX = 4'd8;
  localparam logic [NV_W-1:0] NUM_VARS_RST = 4'd8;

  typedef struct packed {
    logic [VAR_W-1:0] dash;
    logic [VAR_W-1:0] val;
  } term_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_PASS_INIT, ST_I_RD, ST_I_WAIT, ST_J_RD, ST_J_WAIT, ST_K_RD, ST_K_WAIT,
    ST_P_RD, ST_P_WAIT, ST_HI_RD, ST_HI_WAIT, ST_HJ_RD, ST_HJ_WAIT, ST_A_RD, ST_A_WAIT,
    ST_E_RD, ST_E_WAIT, ST_E_HOLD, ST_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_PASS_INIT, OP_I_RD, OP_I_WAIT, OP_J_RD, OP_J_WAIT, OP_K_RD,
    OP_K_WAIT, OP_P_RD, OP_P_WAIT, OP_HI_RD, OP_HI_WAIT, OP_HJ_RD, OP_HJ_WAIT, OP_A_RD,
    OP_A_WAIT, OP_E_RD, OP_E_WAIT, OP_E_HOLD, OP_CLEAR
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   out_valid;
  } dp_cmd_t;

  typedef struct packed {
    logic i_lt_n;
    logic j_lt_n;
    logic k_lt_u;
    logic i_lt_u;
    logic j_lt_u;
    logic merge;
    logic dup;
    logic pair;
    logic e_lt_pc;
  } dp_status_t;

  // clamped variable mask
  function automatic logic [VAR_W-1:0] var_mask(input logic [NV_W-1:0] nv);
    logic [NV_W-1:0] n;
    n = (nv == '0) ? NV_W'(1) : ((nv > NUM_VARS_MAX) ? NUM_VARS_MAX : nv);
    var_mask = VAR_W'((16'd1 << n) - 16'd1);
  endfunction

  // positions with different symbols, dash is a third symbol
  function automatic logic [VAR_W-1:0] diff_of(input term_t a, input term_t b,
                                               input logic [VAR_W-1:0] m);
    diff_of = ((a.dash ^ b.dash) | (~a.dash & ~b.dash & (a.val ^ b.val))) & m;
  endfunction

  function automatic logic single_bit(input logic [VAR_W-1:0] d);
    single_bit = (d != '0) && ((d & (d - VAR_W'(1))) == '0);
  endfunction

endpackage

// File: rtl/pig_if.sv
`timescale 1ns / 1ps
interface pig_term_if;
  logic       valid;
  logic       ready;
  logic [7:0] term_bits;
  logic       last_term;
  modport source (output valid, term_bits, last_term, input ready);
  modport sink (input valid, term_bits, last_term, output ready);
endinterface

interface pig_prime_if;
  logic       valid;
  logic       ready;
  logic [7:0] implicant_value;
  logic [7:0] dash_mask;
  logic       last_prime;
  logic       overflow;
  modport source (output valid, implicant_value, dash_mask, last_prime, overflow,
                  input ready);
  modport sink (input valid, implicant_value, dash_mask, last_prime, overflow,
                output ready);
endinterface

// File: rtl/pig_ctrl.sv
`timescale 1ns / 1ps
module pig_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_last,
  output logic                in_ready,
  input  logic                out_ready,
  input  pig_pkg::dp_status_t status,
  output pig_pkg::dp_cmd_t    cmd
);

  pig_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pig_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd.op        = pig_pkg::OP_NONE;
    cmd.out_valid = 1'b0;
    in_ready      = 1'b0;
    case (state)
      pig_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = pig_pkg::OP_LOAD;
          if (in_last) state_next = pig_pkg::ST_PASS_INIT;
        end
      end
      pig_pkg::ST_PASS_INIT: begin
        cmd.op = pig_pkg::OP_PASS_INIT;
        state_next = pig_pkg::ST_I_RD;
      end
      pig_pkg::ST_I_RD: begin
        cmd.op = pig_pkg::OP_I_RD;
        state_next = status.i_lt_n ? pig_pkg::ST_I_WAIT : pig_pkg::ST_P_RD;
      end
      pig_pkg::ST_I_WAIT: begin
        cmd.op = pig_pkg::OP_I_WAIT;
        state_next = pig_pkg::ST_J_RD;
      end
      pig_pkg::ST_J_RD: begin
        cmd.op = pig_pkg::OP_J_RD;
        state_next = status.j_lt_n ? pig_pkg::ST_J_WAIT : pig_pkg::ST_I_RD;
      end
      pig_pkg::ST_J_WAIT: begin
        cmd.op = pig_pkg::OP_J_WAIT;
        state_next = status.merge ? pig_pkg::ST_K_RD : pig_pkg::ST_J_RD;
      end
      pig_pkg::ST_K_RD: begin
        cmd.op = pig_pkg::OP_K_RD;
        state_next = status.k_lt_u ? pig_pkg::ST_K_WAIT : pig_pkg::ST_J_RD;
      end
      pig_pkg::ST_K_WAIT: begin
        cmd.op = pig_pkg::OP_K_WAIT;
        state_next = status.dup ? pig_pkg::ST_J_RD : pig_pkg::ST_K_RD;
      end
      pig_pkg::ST_P_RD: begin
        cmd.op = pig_pkg::OP_P_RD;
        state_next = status.i_lt_n ? pig_pkg::ST_P_WAIT : pig_pkg::ST_HI_RD;
      end
      pig_pkg::ST_P_WAIT: begin
        cmd.op = pig_pkg::OP_P_WAIT;
        state_next = pig_pkg::ST_P_RD;
      end
      pig_pkg::ST_HI_RD: begin
        cmd.op = pig_pkg::OP_HI_RD;
        state_next = status.i_lt_u ? pig_pkg::ST_HI_WAIT : pig_pkg::ST_A_RD;
      end
      pig_pkg::ST_HI_WAIT: begin
        cmd.op = pig_pkg::OP_HI_WAIT;
        state_next = pig_pkg::ST_HJ_RD;
      end
      pig_pkg::ST_HJ_RD: begin
        cmd.op = pig_pkg::OP_HJ_RD;
        state_next = status.j_lt_u ? pig_pkg::ST_HJ_WAIT : pig_pkg::ST_HI_RD;
      end
      pig_pkg::ST_HJ_WAIT: begin
        cmd.op = pig_pkg::OP_HJ_WAIT;
        state_next = status.pair ? pig_pkg::ST_PASS_INIT : pig_pkg::ST_HJ_RD;
      end
      pig_pkg::ST_A_RD: begin
        cmd.op = pig_pkg::OP_A_RD;
        state_next = status.i_lt_u ? pig_pkg::ST_A_WAIT : pig_pkg::ST_E_RD;
      end
      pig_pkg::ST_A_WAIT: begin
        cmd.op = pig_pkg::OP_A_WAIT;
        state_next = pig_pkg::ST_A_RD;
      end
      pig_pkg::ST_E_RD: begin
        cmd.op = pig_pkg::OP_E_RD;
        state_next = status.e_lt_pc ? pig_pkg::ST_E_WAIT : pig_pkg::ST_DONE;
      end
      pig_pkg::ST_E_WAIT: begin
        cmd.op = pig_pkg::OP_E_WAIT;
        state_next = pig_pkg::ST_E_HOLD;
      end
      pig_pkg::ST_E_HOLD: begin
        cmd.out_valid = 1'b1;
        if (out_ready) begin
          cmd.op = pig_pkg::OP_E_HOLD;
          state_next = pig_pkg::ST_E_RD;
        end
      end
      pig_pkg::ST_DONE: begin
        cmd.op = pig_pkg::OP_CLEAR;
        state_next = pig_pkg::ST_IDLE;
      end
      default: state_next = pig_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: rtl/pig_datapath.sv
`timescale 1ns / 1ps
module pig_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  pig_pkg::dp_cmd_t              cmd,
  input  logic [pig_pkg::NV_W-1:0]      num_vars,
  input  logic [pig_pkg::VAR_W-1:0]     term_bits,
  input  logic                          last_term,
  output pig_pkg::dp_status_t           status,
  output logic [pig_pkg::VAR_W-1:0]     implicant_value,
  output logic [pig_pkg::VAR_W-1:0]     dash_mask,
  output logic                          last_prime,
  output logic                          overflow
);

  localparam logic [pig_pkg::CNT_W-1:0]  FULL  = pig_pkg::CNT_W'(pig_pkg::TERM_DEPTH);
  localparam logic [pig_pkg::PCNT_W-1:0] PFULL = pig_pkg::PCNT_W'(pig_pkg::PRIME_DEPTH);

  pig_pkg::term_t mem_a [pig_pkg::TERM_DEPTH];
  pig_pkg::term_t mem_b [pig_pkg::TERM_DEPTH];
  pig_pkg::term_t mem_p [pig_pkg::PRIME_DEPTH];
  pig_pkg::term_t a_q, b_q, p_q;

  // used flags per column entry, cleared whenever the entry is written
  logic used_a [pig_pkg::TERM_DEPTH];
  logic used_b [pig_pkg::TERM_DEPTH];
  logic ua_q, ub_q, i_used;
  logic uset_we, ua_we, ub_we, u_wd;
  logic [pig_pkg::IDX_W-1:0] u_wa;

  logic [pig_pkg::CNT_W-1:0]  count, n, u, i, j, k;
  logic [pig_pkg::PCNT_W-1:0] pc, e;
  logic cur, ovf;
  pig_pkg::term_t ti, t;

  logic [pig_pkg::VAR_W-1:0] m, d_src, d_dst;
  pig_pkg::term_t src_q, dst_q, merged;
  logic [pig_pkg::IDX_W-1:0] src_ra, dst_ra, a_ra, b_ra, wa;
  logic a_we, b_we, dst_we, p_we;
  pig_pkg::term_t a_wd, dst_wd, p_wd;
  logic [pig_pkg::PIDX_W-1:0] p_ra;

  always_comb begin
    m = pig_pkg::var_mask(num_vars);
    src_q = cur ? b_q : a_q;
    src_q.val = src_q.val & m;
    dst_q = cur ? a_q : b_q;
    d_src = pig_pkg::diff_of(ti, src_q, m);
    d_dst = pig_pkg::diff_of(ti, dst_q, m);
    merged.dash = ti.dash | d_src;
    merged.val  = ti.val & ~merged.dash & m;

    status.i_lt_n  = i < n;
    status.j_lt_n  = j < n;
    status.k_lt_u  = k < u;
    status.i_lt_u  = i < u;
    status.j_lt_u  = j < u;
    status.merge   = pig_pkg::single_bit(d_src);
    status.dup     = dst_q == t;
    status.pair    = pig_pkg::single_bit(d_dst);
    status.e_lt_pc = e < pc;

    src_ra = i[pig_pkg::IDX_W-1:0];
    if (cmd.op == pig_pkg::OP_J_RD) src_ra = j[pig_pkg::IDX_W-1:0];
    case (cmd.op)
      pig_pkg::OP_K_RD:  dst_ra = k[pig_pkg::IDX_W-1:0];
      pig_pkg::OP_HJ_RD: dst_ra = j[pig_pkg::IDX_W-1:0];
      default:           dst_ra = i[pig_pkg::IDX_W-1:0];
    endcase
    a_ra = cur ? dst_ra : src_ra;
    b_ra = cur ? src_ra : dst_ra;

    // new merged term goes to the destination column
    dst_we = (cmd.op == pig_pkg::OP_K_RD) && !status.k_lt_u && (u < FULL);
    dst_wd = t;
    if (cmd.op == pig_pkg::OP_LOAD) begin
      a_we = count < FULL;
      wa   = count[pig_pkg::IDX_W-1:0];
      a_wd.val  = term_bits;
      a_wd.dash = '0;
      b_we = 1'b0;
    end else begin
      a_we = dst_we && cur;
      b_we = dst_we && !cur;
      wa   = u[pig_pkg::IDX_W-1:0];
      a_wd = dst_wd;
    end

    // partner j is marked on a merge, term i once its scan ends
    uset_we = ((cmd.op == pig_pkg::OP_J_WAIT) && status.merge) ||
              ((cmd.op == pig_pkg::OP_J_RD) && !status.j_lt_n && i_used);
    ua_we = a_we || (uset_we && !cur);
    ub_we = b_we || (uset_we && cur);
    u_wd  = !(a_we || b_we);
    if (a_we || b_we) u_wa = wa;
    else if (cmd.op == pig_pkg::OP_J_WAIT) u_wa = j[pig_pkg::IDX_W-1:0];
    else u_wa = i[pig_pkg::IDX_W-1:0];

    p_we = 1'b0;
    p_wd = src_q;
    if (cmd.op == pig_pkg::OP_P_WAIT) begin
      p_we = cur ? !ub_q : !ua_q;
    end else if (cmd.op == pig_pkg::OP_A_WAIT) begin
      p_we = 1'b1;
      p_wd = dst_q;
    end
    p_ra = e[pig_pkg::PIDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (a_we) mem_a[wa] <= a_wd;
    a_q <= mem_a[a_ra];
  end

  always_ff @(posedge clk) begin
    if (b_we) mem_b[wa] <= a_wd;
    b_q <= mem_b[b_ra];
  end

  always_ff @(posedge clk) begin
    if (ua_we) used_a[u_wa] <= u_wd;
    ua_q <= used_a[a_ra];
  end

  always_ff @(posedge clk) begin
    if (ub_we) used_b[u_wa] <= u_wd;
    ub_q <= used_b[b_ra];
  end

  always_ff @(posedge clk) begin
    if (p_we && (pc < PFULL)) mem_p[pc[pig_pkg::PIDX_W-1:0]] <= p_wd;
    p_q <= mem_p[p_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      pc     <= '0;
      ovf    <= 1'b0;
      cur    <= 1'b0;
      i_used <= 1'b0;
      n <= '0; u <= '0; i <= '0; j <= '0; k <= '0; e <= '0;
    end else begin
      if (p_we) begin
        if (pc < PFULL) pc <= pc + 1'b1;
        else ovf <= 1'b1;
      end
      case (cmd.op)
        pig_pkg::OP_LOAD: begin
          if (count < FULL) count <= count + 1'b1;
          else ovf <= 1'b1;
          if (last_term) begin
            n   <= (count < FULL) ? count + 1'b1 : count;
            cur <= 1'b0;
          end
        end
        pig_pkg::OP_PASS_INIT: begin
          u <= '0;
          i <= '0;
        end
        pig_pkg::OP_I_RD, pig_pkg::OP_HI_RD: begin
          j <= i + 1'b1;
          if (cmd.op == pig_pkg::OP_I_RD) i_used <= 1'b0;
          if ((cmd.op == pig_pkg::OP_I_RD) ? !status.i_lt_n : !status.i_lt_u) i <= '0;
        end
        pig_pkg::OP_J_RD: if (!status.j_lt_n) i <= i + 1'b1;
        pig_pkg::OP_J_WAIT: begin
          if (status.merge) begin
            t <= merged;
            i_used <= 1'b1;
            k <= '0;
          end else begin
            j <= j + 1'b1;
          end
        end
        pig_pkg::OP_K_RD: begin
          if (!status.k_lt_u) begin
            if (u < FULL) u <= u + 1'b1;
            else ovf <= 1'b1;
            j <= j + 1'b1;
          end
        end
        pig_pkg::OP_K_WAIT: begin
          if (status.dup) j <= j + 1'b1;
          else k <= k + 1'b1;
        end
        pig_pkg::OP_P_RD: if (!status.i_lt_n) i <= '0;
        pig_pkg::OP_P_WAIT, pig_pkg::OP_A_WAIT: i <= i + 1'b1;
        pig_pkg::OP_HJ_RD: if (!status.j_lt_u) i <= i + 1'b1;
        pig_pkg::OP_HJ_WAIT: begin
          if (status.pair) begin
            cur <= !cur;
            n   <= u;
          end else begin
            j <= j + 1'b1;
          end
        end
        pig_pkg::OP_A_RD: if (!status.i_lt_u) e <= '0;
        pig_pkg::OP_E_HOLD: e <= e + 1'b1;
        pig_pkg::OP_CLEAR: begin
          count <= '0;
          pc    <= '0;
          ovf   <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == pig_pkg::OP_I_WAIT) ti <= src_q;
    else if (cmd.op == pig_pkg::OP_HI_WAIT) ti <= dst_q;
  end

  always_ff @(posedge clk) begin
    if (cmd.op == pig_pkg::OP_E_WAIT) begin
      implicant_value <= p_q.val;
      dash_mask       <= p_q.dash;
      last_prime      <= (e + 1'b1) == pc;
      overflow        <= ovf;
    end
  end

endmodule

// File: rtl/prime_implicant_generator_core.sv
`timescale 1ns / 1ps
// prime implicant generator: terms (minterms and don't-cares alike) enter one item per
// cycle on term_in; the item flagged last_term starts a quine-mccluskey run and no item
// is taken until every prime of that run has left on prime_out. in each column pass a
// run compares every pair of the column, scans the next column for a duplicate on every
// merge, scans the terms for primes and checks the next column for a mergeable pair; the
// final column is then appended to the primes, and each prime is read, registered and
// held on prime_out until the sink takes it; every column step goes through the single
// read port of each column memory.
// up to 256 terms and 64 primes are kept, anything beyond is dropped and overflow is
// raised on every prime of that run. num_vars lives at byte address 0.
module prime_implicant_generator_core (
  input  logic              clk,
  input  logic              rst,
  pig_term_if.sink          term_in,
  pig_prime_if.source       prime_out,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [pig_pkg::NV_W-1:0] num_vars;
  pig_pkg::dp_cmd_t         cmd;
  pig_pkg::dp_status_t      status;

  // config register, word index is paddr[2]
  always_ff @(posedge clk) begin
    if (rst) begin
      num_vars <= pig_pkg::NUM_VARS_RST;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      num_vars <= pwdata[pig_pkg::NV_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {{(32-pig_pkg::NV_W){1'b0}}, num_vars};

  // sequencer
  pig_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (term_in.valid),
    .in_last   (term_in.last_term),
    .in_ready  (term_in.ready),
    .out_ready (prime_out.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // column memories, counters and output register
  pig_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .num_vars        (num_vars),
    .term_bits       (term_in.term_bits),
    .last_term       (term_in.last_term),
    .status          (status),
    .implicant_value (prime_out.implicant_value),
    .dash_mask       (prime_out.dash_mask),
    .last_prime      (prime_out.last_prime),
    .overflow        (prime_out.overflow)
  );

  assign prime_out.valid = cmd.out_valid;

endmodule
